// ===== rtl/e2rm_pkg.sv =====
// Package for the Euler angle to rotation matrix block.
// Holds the request and result payload types, fixed-point constants and
// the rounded Q30 multiply. It depends on nothing else.
package e2rm_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int ANG_W      = 16;
  localparam int OUT_W      = FRAC_BITS + 2;
  localparam int Q_W        = 34;
  localparam int N_LANES    = 6;
  localparam int N_POLY     = 6;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t ONE_Q30 = q_t'(64'sd1 <<< 30);

  localparam q_t POLY_C [N_POLY] = '{
    34'sd1686629713, 34'sd693598668, 34'sd85569306,
    34'sd5026995, 34'sd172272, 34'sd3864
  };

  typedef struct packed {
    logic             op;
    logic [ANG_W-1:0] angle_first;
    logic [ANG_W-1:0] angle_second;
    logic [ANG_W-1:0] angle_third;
  } in_data_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] r0c0;
    logic signed [OUT_W-1:0] r0c1;
    logic signed [OUT_W-1:0] r0c2;
    logic signed [OUT_W-1:0] r1c0;
    logic signed [OUT_W-1:0] r1c1;
    logic signed [OUT_W-1:0] r1c2;
    logic signed [OUT_W-1:0] r2c0;
    logic signed [OUT_W-1:0] r2c1;
    logic signed [OUT_W-1:0] r2c2;
  } out_data_t;

  function automatic q_t qmul(q_t a, q_t b);
    logic signed [2*Q_W-1:0] p;
    p = a * b;
    p = p + ((2*Q_W)'(1) <<< 29);
    return q_t'(p >>> 30);
  endfunction

endpackage

// ===== rtl/euler_to_rotation_matrix.sv =====
// Top level of the Euler angle to rotation matrix block.
// Uses e2rm_pkg for payload types, constants and the Q30 multiply.
//
// Usage:
//   A request on in_data carries a mode bit and three binary angles
//   (a full turn is 2^16). Mode 0 returns the earth-to-navigation matrix
//   from latitude and longitude; mode 1 returns the navigation-to-body
//   matrix from roll, pitch and yaw. The result on out_data holds nine
//   entries in signed Q1.14, saturated to plus or minus 1.0.
//   Both channels use valid and stall; a request moves at a clock edge
//   where valid is high and stall is low.
//   One request is accepted every cycle while the output is not stalled.
//   The pipeline is made of the chain of seven multiplies in each sine
//   polynomial pipeline, two matrix product stages and the output register.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall is raised in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits; no result is pending after reset.
module euler_to_rotation_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  e2rm_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output e2rm_pkg::out_data_t out_data
);

  localparam int NL   = e2rm_pkg::N_LANES;
  localparam int AB   = e2rm_pkg::ANGLE_BITS;
  localparam int FB   = e2rm_pkg::FRAC_BITS;
  localparam int OW   = e2rm_pkg::OUT_W;
  localparam int LAST = 10;

  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
  localparam e2rm_pkg::q_t  RND     = e2rm_pkg::q_t'(64'sd1 <<< (29 - FB));
  localparam e2rm_pkg::q_t  LIM     = e2rm_pkg::q_t'(64'sd1 <<< FB);

  logic                 vp_r  [0:LAST];
  logic                 opp_r [0:LAST-1];
  e2rm_pkg::q_t         xp_r  [0:6][0:NL-1];
  logic                 np_r  [0:6][0:NL-1];
  e2rm_pkg::q_t         up_r  [1:6][0:NL-1];
  e2rm_pkg::q_t         ap_r  [2:6][0:NL-1];
  e2rm_pkg::q_t         sc_r  [7:9][0:NL-1];
  e2rm_pkg::q_t         pr_r  [8:9][0:9];
  e2rm_pkg::q_t         q2_r  [0:3];
  e2rm_pkg::out_data_t  out_r;

  e2rm_pkg::q_t         x_nxt  [0:NL-1];
  logic                 n_nxt  [0:NL-1];
  e2rm_pkg::q_t         sc_nxt [0:NL-1];
  e2rm_pkg::q_t         m_nxt  [0:8];
  e2rm_pkg::out_data_t  out_nxt;
  logic                 adv;

  function automatic logic signed [OW-1:0] to_out(e2rm_pkg::q_t v);
    e2rm_pkg::q_t r;
    r = (v + RND) >>> (30 - FB);
    if (r > LIM) r = LIM;
    if (r < -LIM) r = -LIM;
    return r[OW-1:0];
  endfunction

  assign adv       = !(vp_r[LAST] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vp_r[LAST];
  assign out_data  = out_r;

  always_comb begin
    logic [AB-1:0]   a;
    logic [AB-1:0]   base;
    e2rm_pkg::q_t    xq;
    for (int l = 0; l < NL; l++) begin
      case (l / 2)
        0:       base = in_data.angle_first[AB-1:0];
        1:       base = in_data.angle_second[AB-1:0];
        default: base = in_data.angle_third[AB-1:0];
      endcase
      a  = base + (((l % 2) == 1) ? QUARTER : AB'(0));
      xq = e2rm_pkg::q_t'({a[AB-3:0], {(32 - AB){1'b0}}});
      x_nxt[l] = a[AB-2] ? (e2rm_pkg::ONE_Q30 - xq) : xq;
      n_nxt[l] = a[AB-1];
    end
  end

  always_comb begin
    e2rm_pkg::q_t p;
    for (int l = 0; l < NL; l++) begin
      p = e2rm_pkg::qmul(xp_r[6][l], ap_r[6][l]);
      if (p > e2rm_pkg::ONE_Q30) p = e2rm_pkg::ONE_Q30;
      if (p < 0) p = '0;
      sc_nxt[l] = np_r[6][l] ? -p : p;
    end
  end

  always_comb begin
    if (!opp_r[9]) begin
      m_nxt[0] = -pr_r[9][0];
      m_nxt[1] = -sc_r[9][2];
      m_nxt[2] = -pr_r[9][1];
      m_nxt[3] = -pr_r[9][2];
      m_nxt[4] = sc_r[9][3];
      m_nxt[5] = -pr_r[9][3];
      m_nxt[6] = sc_r[9][1];
      m_nxt[7] = '0;
      m_nxt[8] = -sc_r[9][0];
    end else begin
      m_nxt[0] = pr_r[9][4];
      m_nxt[1] = pr_r[9][5];
      m_nxt[2] = -sc_r[9][2];
      m_nxt[3] = q2_r[0] - pr_r[9][6];
      m_nxt[4] = pr_r[9][7] + q2_r[1];
      m_nxt[5] = pr_r[9][0];
      m_nxt[6] = pr_r[9][8] + q2_r[2];
      m_nxt[7] = q2_r[3] - pr_r[9][9];
      m_nxt[8] = pr_r[9][1];
    end
    out_nxt.r0c0 = to_out(m_nxt[0]);
    out_nxt.r0c1 = to_out(m_nxt[1]);
    out_nxt.r0c2 = to_out(m_nxt[2]);
    out_nxt.r1c0 = to_out(m_nxt[3]);
    out_nxt.r1c1 = to_out(m_nxt[4]);
    out_nxt.r1c2 = to_out(m_nxt[5]);
    out_nxt.r2c0 = to_out(m_nxt[6]);
    out_nxt.r2c1 = to_out(m_nxt[7]);
    out_nxt.r2c2 = to_out(m_nxt[8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LAST; s++) vp_r[s] <= 1'b0;
    end else if (adv) begin
      vp_r[0] <= in_valid;
      for (int s = 1; s <= LAST; s++) vp_r[s] <= vp_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opp_r[0] <= in_data.op;
      for (int s = 1; s < LAST; s++) opp_r[s] <= opp_r[s-1];
      for (int l = 0; l < NL; l++) begin
        xp_r[0][l] <= x_nxt[l];
        np_r[0][l] <= n_nxt[l];
        for (int s = 1; s <= 6; s++) begin
          xp_r[s][l] <= xp_r[s-1][l];
          np_r[s][l] <= np_r[s-1][l];
        end
        up_r[1][l] <= e2rm_pkg::qmul(xp_r[0][l], xp_r[0][l]);
        for (int s = 2; s <= 6; s++) up_r[s][l] <= up_r[s-1][l];
        ap_r[2][l] <= e2rm_pkg::POLY_C[4]
                      - e2rm_pkg::qmul(up_r[1][l], e2rm_pkg::POLY_C[5]);
        for (int s = 3; s <= 6; s++) begin
          ap_r[s][l] <= e2rm_pkg::POLY_C[6-s] - e2rm_pkg::qmul(up_r[s-1][l], ap_r[s-1][l]);
        end
        sc_r[7][l] <= sc_nxt[l];
        sc_r[8][l] <= sc_r[7][l];
        sc_r[9][l] <= sc_r[8][l];
      end
      pr_r[8][0] <= e2rm_pkg::qmul(sc_r[7][0], sc_r[7][3]);
      pr_r[8][1] <= e2rm_pkg::qmul(sc_r[7][1], sc_r[7][3]);
      pr_r[8][2] <= e2rm_pkg::qmul(sc_r[7][0], sc_r[7][2]);
      pr_r[8][3] <= e2rm_pkg::qmul(sc_r[7][1], sc_r[7][2]);
      pr_r[8][4] <= e2rm_pkg::qmul(sc_r[7][3], sc_r[7][5]);
      pr_r[8][5] <= e2rm_pkg::qmul(sc_r[7][3], sc_r[7][4]);
      pr_r[8][6] <= e2rm_pkg::qmul(sc_r[7][1], sc_r[7][4]);
      pr_r[8][7] <= e2rm_pkg::qmul(sc_r[7][1], sc_r[7][5]);
      pr_r[8][8] <= e2rm_pkg::qmul(sc_r[7][0], sc_r[7][4]);
      pr_r[8][9] <= e2rm_pkg::qmul(sc_r[7][0], sc_r[7][5]);
      for (int k = 0; k < 10; k++) pr_r[9][k] <= pr_r[8][k];
      q2_r[0] <= e2rm_pkg::qmul(pr_r[8][2], sc_r[8][5]);
      q2_r[1] <= e2rm_pkg::qmul(pr_r[8][2], sc_r[8][4]);
      q2_r[2] <= e2rm_pkg::qmul(pr_r[8][3], sc_r[8][5]);
      q2_r[3] <= e2rm_pkg::qmul(pr_r[8][3], sc_r[8][4]);
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.r0c0 <= OW'(LIM)) && (out_data.r0c0 >= -OW'(LIM))
                  && (out_data.r2c2 <= OW'(LIM)) && (out_data.r2c2 >= -OW'(LIM)))
    else $error("matrix entry outside unit range");
  a_sine_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vp_r[8] |-> (sc_r[8][0] <= e2rm_pkg::ONE_Q30) && (sc_r[8][0] >= -e2rm_pkg::ONE_Q30))
    else $error("sine lane outside unit range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vp_r[9]) && $stable(vp_r[0]))
    else $error("pipeline moved during stall");
  a_stall_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid) |-> !in_stall)
    else $error("input stalled with empty output stage");
`endif

endmodule

// ===== dv/testbench.sv =====
// Testbench for euler_to_rotation_matrix: drives angle requests with random gaps
// and stalls, predicts each rotation matrix in fixed point and checks every result.
// Depends on e2rm_pkg for the payload types and widths.
module testbench;

  typedef logic signed [63:0] w_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  e2rm_pkg::in_data_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  e2rm_pkg::out_data_t out_data;
  int n_errors = 0;
  int n_checked = 0;
  int n_mode0 = 0;
  int n_mode1 = 0;
  int stall_left = 0;
  bit driving_done = 1'b0;

  always #2 clk = ~clk;

  euler_to_rotation_matrix u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  function automatic w_t floor_shift(w_t v, int s);
    return v >>> s;
  endfunction

  function automatic w_t round_mul(w_t a, w_t b);
    return floor_shift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic w_t quarter_sine(w_t x);
    w_t coef [6];
    w_t u;
    w_t acc;
    coef = '{64'sd1686629713, 64'sd693598668, 64'sd85569306, 64'sd5026995,
             64'sd172272, 64'sd3864};
    u = round_mul(x, x);
    acc = coef[5];
    for (int k = 4; k >= 0; k--) acc = coef[k] - round_mul(u, acc);
    acc = round_mul(x, acc);
    if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
    if (acc < 0) acc = 0;
    return acc;
  endfunction

  function automatic w_t sine_q30(logic [15:0] ang);
    logic [1:0] quad;
    w_t x;
    w_t s;
    quad = ang[15:14];
    x = w_t'({ang[13:0], 16'h0000});
    s = quad[0] ? quarter_sine((64'sd1 <<< 30) - x) : quarter_sine(x);
    return quad[1] ? -s : s;
  endfunction

  function automatic logic signed [e2rm_pkg::OUT_W-1:0] to_q14(w_t v);
    w_t r;
    r = floor_shift(v + (64'sd1 <<< 15), 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[e2rm_pkg::OUT_W-1:0];
  endfunction

  function automatic e2rm_pkg::out_data_t rotation_matrix(e2rm_pkg::in_data_t d);
    w_t s1, c1, s2, c2, s3, c3, sp_st, cp_st;
    w_t m [9];
    e2rm_pkg::out_data_t r;
    s1 = sine_q30(d.angle_first);
    c1 = sine_q30(d.angle_first + 16'h4000);
    s2 = sine_q30(d.angle_second);
    c2 = sine_q30(d.angle_second + 16'h4000);
    s3 = sine_q30(d.angle_third);
    c3 = sine_q30(d.angle_third + 16'h4000);
    if (!d.op) begin
      m = '{-round_mul(s1, c2), -s2, -round_mul(c1, c2), -round_mul(s1, s2), c2,
            -round_mul(c1, s2), c1, 0, -s1};
    end else begin
      sp_st = round_mul(s1, s2);
      cp_st = round_mul(c1, s2);
      m = '{round_mul(c2, c3), round_mul(c2, s3), -s2,
            -round_mul(c1, s3) + round_mul(sp_st, c3),
            round_mul(c1, c3) + round_mul(sp_st, s3), round_mul(s1, c2),
            round_mul(s1, s3) + round_mul(cp_st, c3),
            -round_mul(s1, c3) + round_mul(cp_st, s3), round_mul(c1, c2)};
    end
    r = '{to_q14(m[0]), to_q14(m[1]), to_q14(m[2]), to_q14(m[3]), to_q14(m[4]),
          to_q14(m[5]), to_q14(m[6]), to_q14(m[7]), to_q14(m[8])};
    return r;
  endfunction

  class matrix_scoreboard;
    e2rm_pkg::out_data_t pending [$];

    function void note_request(e2rm_pkg::in_data_t d);
      pending.push_back(rotation_matrix(d));
    endfunction

    task check_result(e2rm_pkg::out_data_t got);
      e2rm_pkg::out_data_t want;
      logic signed [e2rm_pkg::OUT_W-1:0] g [9];
      logic signed [e2rm_pkg::OUT_W-1:0] w [9];
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, pending count", 1, 0);
        return;
      end
      want = pending.pop_front();
      g = '{got.r0c0, got.r0c1, got.r0c2, got.r1c0, got.r1c1, got.r1c2,
            got.r2c0, got.r2c1, got.r2c2};
      w = '{want.r0c0, want.r0c1, want.r0c2, want.r1c0, want.r1c1, want.r1c2,
            want.r2c0, want.r2c1, want.r2c2};
      for (int i = 0; i < 9; i++)
        if (g[i] !== w[i]) report_mismatch($sformatf("entry r%0dc%0d", i / 3, i % 3),
                                           int'(g[i]), int'(w[i]));
      n_checked++;
    endtask
  endclass

  matrix_scoreboard sb = new();

  function automatic int gap_length();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input e2rm_pkg::in_data_t d);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(d);
    if (d.op) n_mode1++; else n_mode0++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    logic [15:0] pts [12];
    pts = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF,
            16'h8000, 16'h8001, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF};
    if ($urandom_range(9) < 2) return pts[$urandom_range(11)];
    return 16'($urandom());
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < 70) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(99) < 90) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      stall_left = $urandom_range(8, 40);
      out_stall <= 1'b1;
    end
  end

  initial begin
    e2rm_pkg::in_data_t d;
    logic [15:0] corners [6];
    corners = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 12; i++) begin
      d.op = i[0];
      d.angle_first = corners[i % 6];
      d.angle_second = corners[(i / 2) % 6];
      d.angle_third = corners[(i + 3) % 6];
      send_request(d);
    end
    d = '{1'b0, 16'h1234, 16'h5678, 16'hFFFF};
    send_request(d);
    d = '{1'b0, 16'h1234, 16'h5678, 16'h0000};
    send_request(d);
    d = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_request(d);
    d = '{1'b1, 16'h0001, 16'h7FFF, 16'h8001};
    send_request(d);
    for (int n = 0; n < 1050; n++) begin
      if (n == 500) drain_results();
      d.op = 1'($urandom());
      d.angle_first = pick_angle();
      d.angle_second = pick_angle();
      d.angle_third = pick_angle();
      send_request(d);
    end
    drain_results();
    repeat (30) @(posedge clk);
    $display("covered %0d mode-0 and %0d mode-1 requests, %0d matrices checked",
             n_mode0, n_mode1, n_checked);
    if (n_errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("testbench: FAIL");
    $finish;
  end
endmodule
